// ===== rtl/segment_intersection_2d_top_assert.svh =====
// assertion macros for the segment intersection block
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef SEGMENT_INTERSECTION_2D_TOP_ASSERT_SVH
`define SEGMENT_INTERSECTION_2D_TOP_ASSERT_SVH

// same-cycle implication, off while in reset
`define SEGI2D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define SEGI2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/segi2d_pkg.sv =====
// shared widths, register map and sideband type for the segment intersection block
// no dependencies
package segi2d_pkg;

    localparam int CW        = 24;          // coordinate width, Q12.12
    localparam int DW        = CW + 1;      // coordinate difference
    localparam int PW        = 2 * DW;      // cross product term
    localparam int WW        = PW + 1;      // denominator and numerators
    localparam int LIMIT_W   = 50;
    localparam int UA_FRAC   = 24;
    localparam int QW        = UA_FRAC + 1; // ua in [0,1] with UA_FRAC fraction bits
    localparam int MW        = CW + QW;     // span magnitude times ua
    localparam int DIV_STEPS = QW;
    localparam int PRE_STAGES  = 4;
    localparam int POST_STAGES = 2;
    localparam int LAT       = PRE_STAGES + DIV_STEPS + POST_STAGES;

    localparam int APB_AW    = 4;
    localparam int APB_DW    = 64;
    localparam int ADDR_LSB  = 3;
    localparam int REG_IDX_W = APB_AW - ADDR_LSB;

    localparam logic [REG_IDX_W-1:0] REG_PARALLEL_LIMIT = REG_IDX_W'(0);
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET        = LIMIT_W'(168);
    localparam logic [QW-1:0]        UA_ONE             = {1'b1, {UA_FRAC{1'b0}}};

    typedef struct packed {
        logic                  hit;
        logic signed [CW-1:0]  asx;
        logic signed [CW-1:0]  asy;
        logic                  negx;
        logic                  negy;
        logic [CW-1:0]         magx;
        logic [CW-1:0]         magy;
    } t_side;

endpackage

// ===== rtl/segi2d_div.sv =====
// pipelined restoring divider, one quotient bit per stage, carries a sideband beat along
// depends on segi2d_pkg
module segi2d_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  segi2d_pkg::t_side             i_side,
    input  logic [segi2d_pkg::WW-1:0]     i_num,
    input  logic [segi2d_pkg::WW-1:0]     i_den,
    output logic                          o_valid,
    output segi2d_pkg::t_side             o_side,
    output logic [segi2d_pkg::QW-1:0]     o_quot
);

    logic                        r_valid [segi2d_pkg::DIV_STEPS];
    segi2d_pkg::t_side           r_side  [segi2d_pkg::DIV_STEPS];
    logic [segi2d_pkg::WW-1:0]   r_rem   [segi2d_pkg::DIV_STEPS];
    logic [segi2d_pkg::WW-1:0]   r_den   [segi2d_pkg::DIV_STEPS];
    logic [segi2d_pkg::QW-1:0]   r_quo   [segi2d_pkg::DIV_STEPS];

    for (genvar g = 0; g < segi2d_pkg::DIV_STEPS; g++) begin : g_step
        logic                        w_v_in;
        segi2d_pkg::t_side           w_side_in;
        logic [segi2d_pkg::WW-1:0]   w_den_in;
        logic [segi2d_pkg::WW-1:0]   w_trial;
        logic [segi2d_pkg::QW-1:0]   w_quo_in;
        logic                        w_ge;

        if (g == 0) begin : g_first
            // integer bit: no shift before the first compare
            assign w_v_in    = i_valid;
            assign w_side_in = i_side;
            assign w_den_in  = i_den;
            assign w_trial   = i_num;
            assign w_quo_in  = '0;
        end else begin : g_next
            assign w_v_in    = r_valid[g-1];
            assign w_side_in = r_side[g-1];
            assign w_den_in  = r_den[g-1];
            assign w_trial   = {r_rem[g-1][segi2d_pkg::WW-2:0], 1'b0};
            assign w_quo_in  = r_quo[g-1];
        end

        assign w_ge = (w_trial >= w_den_in);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else begin
                r_valid[g] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[g] <= w_side_in;
            r_den[g]  <= w_den_in;
            r_rem[g]  <= w_ge ? (w_trial - w_den_in) : w_trial;
            r_quo[g]  <= {w_quo_in[segi2d_pkg::QW-2:0], w_ge};
        end
    end

    assign o_valid = r_valid[segi2d_pkg::DIV_STEPS-1];
    assign o_side  = r_side[segi2d_pkg::DIV_STEPS-1];
    assign o_quot  = r_quo[segi2d_pkg::DIV_STEPS-1];

endmodule

// ===== rtl/segment_intersection_2d_top.sv =====
// top level of the 2d segment intersection block: front stages, divider, lerp, apb register
// depends on segi2d_pkg, segi2d_div and segment_intersection_2d_top_assert.svh
//
//  port group        dir   handshake                     payload
//  command           in    start, busy                   i_a_*, i_b_* (8 x 24b signed)
//  result            out   o_done (one-cycle strobe)     o_hit, o_cross_x, o_cross_y
//  register          apb   psel, penable, pwrite, pready paddr, pwdata, prdata
//
// one beat accepted per cycle; busy is always low
// each result passes through 4 front stages, a
// 25-stage divider (one quotient bit per stage) and 2 lerp stages
// synchronous reset clears the valid bits and sets parallel_limit to 168
// the receiver has no back-pressure, so nothing ever stalls
`include "segment_intersection_2d_top_assert.svh"

module segment_intersection_2d_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [segi2d_pkg::CW-1:0]        i_a_start_x,
    input  logic signed [segi2d_pkg::CW-1:0]        i_a_start_y,
    input  logic signed [segi2d_pkg::CW-1:0]        i_a_end_x,
    input  logic signed [segi2d_pkg::CW-1:0]        i_a_end_y,
    input  logic signed [segi2d_pkg::CW-1:0]        i_b_start_x,
    input  logic signed [segi2d_pkg::CW-1:0]        i_b_start_y,
    input  logic signed [segi2d_pkg::CW-1:0]        i_b_end_x,
    input  logic signed [segi2d_pkg::CW-1:0]        i_b_end_y,
    output logic                                    o_done,
    output logic                                    o_hit,
    output logic signed [segi2d_pkg::CW-1:0]        o_cross_x,
    output logic signed [segi2d_pkg::CW-1:0]        o_cross_y,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [segi2d_pkg::APB_AW-1:0]           paddr,
    input  logic [segi2d_pkg::APB_DW-1:0]           pwdata,
    output logic [segi2d_pkg::APB_DW-1:0]           prdata,
    output logic                                    pready
);

    localparam int CW = segi2d_pkg::CW;
    localparam int DW = segi2d_pkg::DW;
    localparam int PW = segi2d_pkg::PW;
    localparam int WW = segi2d_pkg::WW;
    localparam int QW = segi2d_pkg::QW;
    localparam int MW = segi2d_pkg::MW;

    // ---------------- register port ----------------
    logic [segi2d_pkg::LIMIT_W-1:0]   r_limit;
    logic [segi2d_pkg::REG_IDX_W-1:0] w_reg_idx;
    logic                             w_wr;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign w_reg_idx = paddr[segi2d_pkg::APB_AW-1:segi2d_pkg::ADDR_LSB];
    assign w_wr      = psel && penable && pwrite && pready
                       && (w_reg_idx == segi2d_pkg::REG_PARALLEL_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= segi2d_pkg::LIMIT_RESET;
        end else if (w_wr) begin
            r_limit <= pwdata[segi2d_pkg::LIMIT_W-1:0];
        end
    end

    assign prdata = (w_reg_idx == segi2d_pkg::REG_PARALLEL_LIMIT)
                    ? segi2d_pkg::APB_DW'(r_limit) : '0;

    // ---------------- stage 1: differences ----------------
    logic w_acc;
    logic r_v1;
    logic signed [CW-1:0] r1_asx, r1_asy;
    logic signed [DW-1:0] r1_dx1, r1_dy1, r1_dx2, r1_dy2, r1_ox, r1_oy;

    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_asx <= i_a_start_x;
        r1_asy <= i_a_start_y;
        r1_dx1 <= {i_a_end_x[CW-1], i_a_end_x} - {i_a_start_x[CW-1], i_a_start_x};
        r1_dy1 <= {i_a_end_y[CW-1], i_a_end_y} - {i_a_start_y[CW-1], i_a_start_y};
        r1_dx2 <= {i_b_end_x[CW-1], i_b_end_x} - {i_b_start_x[CW-1], i_b_start_x};
        r1_dy2 <= {i_b_end_y[CW-1], i_b_end_y} - {i_b_start_y[CW-1], i_b_start_y};
        r1_ox  <= {i_a_start_x[CW-1], i_a_start_x} - {i_b_start_x[CW-1], i_b_start_x};
        r1_oy  <= {i_a_start_y[CW-1], i_a_start_y} - {i_b_start_y[CW-1], i_b_start_y};
    end

    // ---------------- stage 2: cross product terms ----------------
    logic r_v2;
    logic signed [CW-1:0] r2_asx, r2_asy;
    logic                 r2_negx, r2_negy;
    logic [CW-1:0]        r2_magx, r2_magy;
    logic signed [PW-1:0] r2_den_a, r2_den_b, r2_na_a, r2_na_b, r2_nb_a, r2_nb_b;
    logic [DW-1:0]        w_absx, w_absy;

    // span magnitudes stay below 2**CW
    assign w_absx = r1_dx1[DW-1] ? (DW'(0) - DW'(r1_dx1)) : DW'(r1_dx1);
    assign w_absy = r1_dy1[DW-1] ? (DW'(0) - DW'(r1_dy1)) : DW'(r1_dy1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_asx   <= r1_asx;
        r2_asy   <= r1_asy;
        r2_negx  <= r1_dx1[DW-1];
        r2_negy  <= r1_dy1[DW-1];
        r2_magx  <= w_absx[CW-1:0];
        r2_magy  <= w_absy[CW-1:0];
        r2_den_a <= PW'(r1_dy2) * PW'(r1_dx1);
        r2_den_b <= PW'(r1_dx2) * PW'(r1_dy1);
        r2_na_a  <= PW'(r1_dx2) * PW'(r1_oy);
        r2_na_b  <= PW'(r1_dy2) * PW'(r1_ox);
        r2_nb_a  <= PW'(r1_dx1) * PW'(r1_oy);
        r2_nb_b  <= PW'(r1_dy1) * PW'(r1_ox);
    end

    // ---------------- stage 3: denominator and numerators ----------------
    logic r_v3;
    logic signed [CW-1:0] r3_asx, r3_asy;
    logic                 r3_negx, r3_negy;
    logic [CW-1:0]        r3_magx, r3_magy;
    logic signed [WW-1:0] r3_den, r3_na, r3_nb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_asx  <= r2_asx;
        r3_asy  <= r2_asy;
        r3_negx <= r2_negx;
        r3_negy <= r2_negy;
        r3_magx <= r2_magx;
        r3_magy <= r2_magy;
        r3_den  <= {r2_den_a[PW-1], r2_den_a} - {r2_den_b[PW-1], r2_den_b};
        r3_na   <= {r2_na_a[PW-1], r2_na_a} - {r2_na_b[PW-1], r2_na_b};
        r3_nb   <= {r2_nb_a[PW-1], r2_nb_a} - {r2_nb_b[PW-1], r2_nb_b};
    end

    // ---------------- stage 4: hit decision, divider operands ----------------
    logic [WW-1:0]     w_ad, w_ana, w_anb;
    logic              w_big, w_ua_ok, w_ub_ok, w_hit;
    logic              r_v4;
    segi2d_pkg::t_side r4_side;
    logic [WW-1:0]     r4_num, r4_den;

    assign w_ad  = r3_den[WW-1] ? (WW'(0) - WW'(r3_den)) : WW'(r3_den);
    assign w_ana = r3_na[WW-1]  ? (WW'(0) - WW'(r3_na))  : WW'(r3_na);
    assign w_anb = r3_nb[WW-1]  ? (WW'(0) - WW'(r3_nb))  : WW'(r3_nb);

    assign w_big   = (w_ad > WW'(r_limit));
    // parameter in [0,1]: same sign as the denominator (or zero) and no larger
    assign w_ua_ok = ((r3_na == '0) || (r3_na[WW-1] == r3_den[WW-1])) && (w_ad >= w_ana);
    assign w_ub_ok = ((r3_nb == '0) || (r3_nb[WW-1] == r3_den[WW-1])) && (w_ad >= w_anb);
    assign w_hit   = w_big && w_ua_ok && w_ub_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_side.hit  <= w_hit;
        r4_side.asx  <= r3_asx;
        r4_side.asy  <= r3_asy;
        r4_side.negx <= r3_negx;
        r4_side.negy <= r3_negy;
        r4_side.magx <= r3_magx;
        r4_side.magy <= r3_magy;
        r4_num       <= w_ana;
        r4_den       <= w_ad;
    end

    // ---------------- divider: ua = |na| / |den| ----------------
    logic              w_div_valid;
    segi2d_pkg::t_side w_div_side;
    logic [QW-1:0]     w_div_quot;

    segi2d_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .i_side  (r4_side),
        .i_num   (r4_num),
        .i_den   (r4_den),
        .o_valid (w_div_valid),
        .o_side  (w_div_side),
        .o_quot  (w_div_quot)
    );

    // ---------------- lerp multiply ----------------
    logic                 r_vm;
    logic                 rm_hit, rm_negx, rm_negy;
    logic signed [CW-1:0] rm_asx, rm_asy;
    logic [MW-1:0]        rm_px, rm_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else begin
            r_vm <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        rm_hit  <= w_div_side.hit;
        rm_negx <= w_div_side.negx;
        rm_negy <= w_div_side.negy;
        rm_asx  <= w_div_side.asx;
        rm_asy  <= w_div_side.asy;
        rm_px   <= MW'(w_div_side.magx) * MW'(w_div_quot);
        rm_py   <= MW'(w_div_side.magy) * MW'(w_div_quot);
    end

    // ---------------- output register ----------------
    logic [CW-1:0] w_offx, w_offy, w_cx, w_cy;

    // offset truncated toward zero, sum wraps to the coordinate width
    assign w_offx = rm_px[segi2d_pkg::UA_FRAC +: CW];
    assign w_offy = rm_py[segi2d_pkg::UA_FRAC +: CW];
    assign w_cx   = rm_negx ? (CW'(rm_asx) - w_offx) : (CW'(rm_asx) + w_offx);
    assign w_cy   = rm_negy ? (CW'(rm_asy) - w_offy) : (CW'(rm_asy) + w_offy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        o_hit     <= rm_hit;
        o_cross_x <= rm_hit ? signed'(w_cx) : '0;
        o_cross_y <= rm_hit ? signed'(w_cy) : '0;
    end

    // ---------------- checks ----------------
    `SEGI2D_ASSERT_NOW(a_miss_zero, o_done && !o_hit, (o_cross_x == '0) && (o_cross_y == '0), "miss beat with nonzero crossing point")
    `SEGI2D_ASSERT_NOW(a_ua_range, w_div_valid && w_div_side.hit, w_div_quot <= segi2d_pkg::UA_ONE, "ua above one on a hit")
    `SEGI2D_ASSERT_NOW(a_latency, o_done, $past(start, segi2d_pkg::LAT), "result strobe without a command beat at fixed latency")
    `SEGI2D_ASSERT_NEXT(a_front_flow, r_v1, r_v2, "front pipeline dropped a beat")

endmodule

// ===== tb/tb_segment_intersection_2d_top.sv =====
// self-checking testbench for segment_intersection_2d_top: directed table, then random segment pairs
// depends on segi2d_pkg and the rtl of segment_intersection_2d_top; apb writes the parallel limit
module tb_segment_intersection_2d_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW       = segi2d_pkg::CW;
    localparam int APB_AW   = segi2d_pkg::APB_AW;
    localparam int APB_DW   = segi2d_pkg::APB_DW;
    localparam int ADDR_LSB = segi2d_pkg::ADDR_LSB;
    localparam int LIMIT_W  = segi2d_pkg::LIMIT_W;
    localparam int UA_FRAC  = segi2d_pkg::UA_FRAC;
    localparam int LAT      = segi2d_pkg::LAT;

    localparam int C_MAX          = (1 << (CW - 1)) - 1;
    localparam int C_MIN          = -(1 << (CW - 1));
    localparam int ONE            = 1 << 12;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 192;
    localparam int QUIET_PHASE    = 2;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [APB_AW-1:0] ADDR_LIMIT    =
        APB_AW'(segi2d_pkg::REG_PARALLEL_LIMIT) << ADDR_LSB;
    localparam logic [APB_AW-1:0] ADDR_UNMAPPED =
        APB_AW'(int'(segi2d_pkg::REG_PARALLEL_LIMIT) + 1) << ADDR_LSB;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic signed [CW-1:0] asx;
        logic signed [CW-1:0] asy;
        logic signed [CW-1:0] aex;
        logic signed [CW-1:0] aey;
        logic signed [CW-1:0] bsx;
        logic signed [CW-1:0] bsy;
        logic signed [CW-1:0] bex;
        logic signed [CW-1:0] bey;
    } t_seg_pair;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_crossing;

    typedef struct {
        t_seg_pair seg;
        bit        typed;
        t_crossing want;
    } t_directed_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_seg_pair           cmd;
    logic                o_done;
    logic                o_hit;
    logic signed [CW-1:0] o_cross_x;
    logic signed [CW-1:0] o_cross_y;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // typed expectation that rides along with the beat on the command port
    bit                  want_typed;
    t_crossing           want_fixed;

    logic [LIMIT_W-1:0]  limit_q = segi2d_pkg::LIMIT_RESET;
    t_crossing           crossing_q[$];
    t_directed_row       directed_tab[$];
    int                  mismatch_cnt = 0;
    int                  stall_cnt = 0;

    segment_intersection_2d_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_a_start_x (cmd.asx),
        .i_a_start_y (cmd.asy),
        .i_a_end_x   (cmd.aex),
        .i_a_end_y   (cmd.aey),
        .i_b_start_x (cmd.bsx),
        .i_b_start_y (cmd.bsy),
        .i_b_end_x   (cmd.bex),
        .i_b_end_y   (cmd.bey),
        .o_done      (o_done),
        .o_hit       (o_hit),
        .o_cross_x   (o_cross_x),
        .o_cross_y   (o_cross_y),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_wide widen(input logic signed [CW-1:0] v);
        t_wide w;
        w = 128'(v);
        return w;
    endfunction

    function automatic t_wide wabs(input t_wide v);
        return (v < 0) ? -v : v;
    endfunction

    // num/den in [0,1] without dividing
    function automatic bit within_span(input t_wide num, input t_wide den);
        if (num != 0 && ((num < 0) != (den < 0)))
            return 1'b0;
        return wabs(den) >= wabs(num);
    endfunction

    function automatic t_crossing predict_crossing(input t_seg_pair p,
                                                   input logic [LIMIT_W-1:0] lim);
        t_wide     sx, sy, dx1, dy1, dx2, dy2, ox, oy;
        t_wide     den, na, nb, mag_den, lim_w, ua_q, px, py;
        t_crossing r;
        sx  = widen(p.asx);
        sy  = widen(p.asy);
        dx1 = widen(p.aex) - sx;
        dy1 = widen(p.aey) - sy;
        dx2 = widen(p.bex) - widen(p.bsx);
        dy2 = widen(p.bey) - widen(p.bsy);
        ox  = sx - widen(p.bsx);
        oy  = sy - widen(p.bsy);
        den = dy2 * dx1 - dx2 * dy1;
        na  = dx2 * oy - dy2 * ox;
        nb  = dx1 * oy - dy1 * ox;
        mag_den = wabs(den);
        lim_w = '0;
        lim_w[LIMIT_W-1:0] = lim;
        r = '0;
        if (mag_den > lim_w && within_span(na, den) && within_span(nb, den)) begin
            // ua truncated to UA_FRAC bits, offset truncated toward zero
            ua_q = (wabs(na) <<< UA_FRAC) / mag_den;
            px = (wabs(dx1) * ua_q) >>> UA_FRAC;
            py = (wabs(dy1) * ua_q) >>> UA_FRAC;
            px = (dx1 < 0) ? sx - px : sx + px;
            py = (dy1 < 0) ? sy - py : sy + py;
            r.hit = 1'b1;
            r.x   = px[CW-1:0];
            r.y   = py[CW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [CW-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0:       return CW'(C_MIN);
            1:       return CW'(C_MAX);
            2:       return '0;
            3:       return '1;
            4:       return CW'(1);
            default: return CW'($urandom());
        endcase
    endfunction

    function automatic t_seg_pair gen_pair();
        t_seg_pair            p;
        logic signed [CW-1:0] tmp;
        int                   kind, cx, cy, vx, vy, wx, wy, s1, s2, dx, dy;
        kind = $urandom_range(0, 99);
        cx = int'($urandom_range(0, 4194304)) - 2097152;
        cy = int'($urandom_range(0, 4194304)) - 2097152;
        vx = int'($urandom_range(0, 2097152)) - 1048576;
        vy = int'($urandom_range(0, 2097152)) - 1048576;
        wx = int'($urandom_range(0, 2097152)) - 1048576;
        wy = int'($urandom_range(0, 2097152)) - 1048576;
        s1 = $urandom_range(0, 3);
        s2 = $urandom_range(0, 3);
        if (kind < 45) begin
            // both segments pass through (cx, cy)
            p.asx = CW'(cx - vx);
            p.asy = CW'(cy - vy);
            p.aex = CW'(cx + (vx >>> s1));
            p.aey = CW'(cy + (vy >>> s1));
            p.bsx = CW'(cx - wx);
            p.bsy = CW'(cy - wy);
            p.bex = CW'(cx + (wx >>> s2));
            p.bey = CW'(cy + (wy >>> s2));
            if ($urandom_range(0, 1)) begin
                tmp = p.bsx; p.bsx = p.bex; p.bex = tmp;
                tmp = p.bsy; p.bsy = p.bey; p.bey = tmp;
            end
        end else if (kind < 55) begin
            // b starts on an endpoint of a
            p.asx = CW'(cx - vx);
            p.asy = CW'(cy - vy);
            p.aex = CW'(cx + vx);
            p.aey = CW'(cy + vy);
            p.bsx = $urandom_range(0, 1) ? p.asx : p.aex;
            p.bsy = (p.bsx == p.asx) ? p.asy : p.aey;
            p.bex = CW'(cx + wx);
            p.bey = CW'(cy + wy);
        end else if (kind < 65) begin
            // b nearly parallel to a, denominator near the limit
            dx = int'($urandom_range(0, 32)) - 16;
            dy = int'($urandom_range(0, 32)) - 16;
            p.asx = CW'(vx >>> 8);
            p.asy = CW'(vy >>> 8);
            p.aex = CW'(wx >>> 8);
            p.aey = CW'(wy >>> 8);
            p.bsx = CW'(p.asx + dx);
            p.bsy = CW'(p.asy + dy);
            p.bex = CW'(p.aex + dx + int'($urandom_range(0, 4)) - 2);
            p.bey = CW'(p.aey + dy + int'($urandom_range(0, 4)) - 2);
        end else if (kind < 75) begin
            p.asx = CW'(int'($urandom_range(0, 16)) - 8);
            p.asy = CW'(int'($urandom_range(0, 16)) - 8);
            p.aex = CW'(int'($urandom_range(0, 16)) - 8);
            p.aey = CW'(int'($urandom_range(0, 16)) - 8);
            p.bsx = CW'(int'($urandom_range(0, 16)) - 8);
            p.bsy = CW'(int'($urandom_range(0, 16)) - 8);
            p.bex = CW'(int'($urandom_range(0, 16)) - 8);
            p.bey = CW'(int'($urandom_range(0, 16)) - 8);
        end else if (kind < 85) begin
            p.asx = pick_extreme();
            p.asy = pick_extreme();
            p.aex = pick_extreme();
            p.aey = pick_extreme();
            p.bsx = pick_extreme();
            p.bsy = pick_extreme();
            p.bex = pick_extreme();
            p.bey = pick_extreme();
        end else begin
            p.asx = CW'($urandom());
            p.asy = CW'($urandom());
            p.aex = CW'($urandom());
            p.aey = CW'($urandom());
            p.bsx = CW'($urandom());
            p.bsy = CW'($urandom());
            p.bex = CW'($urandom());
            p.bey = CW'($urandom());
        end
        return p;
    endfunction

    task automatic add_row(input int asx, asy, aex, aey, bsx, bsy, bex, bey,
                           input bit typed, input bit hit, input int x, input int y);
        t_directed_row row;
        row.seg.asx  = CW'(asx);
        row.seg.asy  = CW'(asy);
        row.seg.aex  = CW'(aex);
        row.seg.aey  = CW'(aey);
        row.seg.bsx  = CW'(bsx);
        row.seg.bsy  = CW'(bsy);
        row.seg.bex  = CW'(bex);
        row.seg.bey  = CW'(bey);
        row.typed    = typed;
        row.want.hit = hit;
        row.want.x   = CW'(x);
        row.want.y   = CW'(y);
        directed_tab.insert(directed_tab.size(), row);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch %0d at %0t: %s", mismatch_cnt, $realtime, what);
    endtask

    task automatic send_pair(input t_seg_pair p, input bit typed, input t_crossing want);
        @(negedge i_clk);
        cmd        <= p;
        start      <= 1'b1;
        want_typed <= typed;
        want_fixed <= want;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_cycle();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // every beat yields a result, so an empty queue plus the pipeline depth means idle
    task automatic drain();
        while (crossing_q.size() != 0) @(posedge i_clk);
        repeat (LAT + 2) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_limit();
        logic [APB_DW-1:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_LIMIT;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        want = APB_DW'(limit_q);
        if (prdata !== want)
            report_mismatch($sformatf("parallel_limit read exp %0h got %0h", want, prdata));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // scoreboard, register shadow and watchdog
    always @(posedge i_clk) begin : monitor
        t_crossing exp_c;
        bit        moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_done) begin
                moved = 1'b1;
                if (crossing_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result hit=%0b x=%0d y=%0d",
                                              o_hit, o_cross_x, o_cross_y));
                end else begin
                    exp_c = crossing_q.pop_front();
                    if (o_hit !== exp_c.hit || o_cross_x !== exp_c.x || o_cross_y !== exp_c.y)
                        report_mismatch($sformatf(
                            "exp hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                            exp_c.hit, exp_c.x, exp_c.y, o_hit, o_cross_x, o_cross_y));
                end
            end
            if (start && !busy) begin
                moved = 1'b1;
                crossing_q.insert(crossing_q.size(),
                                  want_typed ? want_fixed : predict_crossing(cmd, limit_q));
            end
            if (psel && penable && pready) begin
                moved = 1'b1;
                if (pwrite && paddr[APB_AW-1:ADDR_LSB] == segi2d_pkg::REG_PARALLEL_LIMIT)
                    limit_q = pwdata[LIMIT_W-1:0];
            end
        end
        if (moved)
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_seg_pair p;
        t_crossing none;
        int        i, ph;
        none       = '0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        want_typed = 1'b0;
        want_fixed = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;

        // directed pairs at the reset limit
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(-ONE, 0, ONE, 0, 0, -ONE, 0, ONE, 1, 1, 0, 0);
        add_row(ONE, 0, -ONE, 0, 0, ONE, 0, -ONE, 1, 1, 0, 0);
        add_row(0, 0, ONE, 0, ONE, -ONE, ONE, ONE, 1, 1, ONE, 0);
        add_row(0, 0, ONE, 0, 0, -ONE, 0, ONE, 1, 1, 0, 0);
        add_row(0, 0, 2 * ONE, 0, ONE, 0, ONE, ONE, 1, 1, ONE, 0);
        add_row(0, 0, 2 * ONE, 0, ONE, ONE, ONE, 0, 1, 1, ONE, 0);
        add_row(0, 0, ONE, 0, 2 * ONE, -ONE, 2 * ONE, ONE, 1, 0, 0, 0);
        add_row(0, 0, ONE, 0, -ONE, -ONE, -ONE, ONE, 1, 0, 0, 0);
        add_row(0, 0, ONE, 0, 0, ONE, ONE, ONE, 1, 0, 0, 0);
        add_row(0, 0, 2 * ONE, 0, ONE, 0, 3 * ONE, 0, 1, 0, 0, 0);
        add_row(ONE, ONE, ONE, ONE, 0, 0, 2 * ONE, 2 * ONE, 1, 0, 0, 0);
        // denominator right at, just above, and just below minus the limit
        add_row(0, 0, 1, 0, 0, -84, 0, 84, 1, 0, 0, 0);
        add_row(0, 0, 1, 0, 0, -84, 0, 85, 1, 1, 0, 0);
        add_row(0, 0, 1, 0, 0, 85, 0, -84, 1, 1, 0, 0);
        add_row(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1, 0, 0, 0);
        add_row(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1, 0, 0, 0);
        add_row(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, 0, 0, 0, 0);
        add_row(C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, 0, 0, 0, 0);
        add_row(C_MIN, 0, C_MAX, 0, 0, C_MIN, 0, C_MAX, 0, 0, 0, 0);
        add_row(C_MIN, C_MAX, C_MAX, C_MIN, 0, C_MIN, 0, C_MAX, 0, 0, 0, 0);
        add_row(-3 * ONE + 123, 777, 5 * ONE, -2 * ONE + 5, -ONE, 4 * ONE, 2 * ONE + 17,
                -3 * ONE, 0, 0, 0, 0);
        add_row(1000, -2000, -30000, 25000, -20000, -20000, 10000, 15000, 0, 0, 0, 0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        apb_read_limit();
        for (i = 0; i < directed_tab.size(); i++) begin
            if ($urandom_range(0, 99) < 9)
                idle_cycle();
            send_pair(directed_tab[i].seg, directed_tab[i].typed, directed_tab[i].want);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            idle_cycle();
            drain();
            case (ph)
                0: apb_write(ADDR_LIMIT, '1);
                1: apb_write(ADDR_LIMIT, '0);
                2: apb_write(ADDR_LIMIT, APB_DW'($urandom_range(0, 1 << 24)));
                3: apb_write(ADDR_LIMIT, {$urandom(), $urandom()});
                4: begin
                    apb_write(ADDR_LIMIT, APB_DW'(segi2d_pkg::LIMIT_RESET));
                    // no register behind this address
                    apb_write(ADDR_UNMAPPED, {$urandom(), $urandom()});
                end
                default: apb_write(ADDR_LIMIT, APB_DW'($urandom_range(0, 4096)));
            endcase
            apb_read_limit();
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (ph != QUIET_PHASE && $urandom_range(0, 99) < 9)
                    idle_cycle();
                p = gen_pair();
                send_pair(p, 1'b0, none);
            end
        end

        idle_cycle();
        drain();
        if (mismatch_cnt == 0 && crossing_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
